// ===== rtl/core/dmlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dmlr_pkg
// Shared types and constants for the downmix and linear resampler.
// ----------------------------------------------------------------------------
package dmlr_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_UPSAMPLE = 8;
  localparam int STEP_W       = 20;
  localparam int SRC_W        = 3;
  localparam int CHOICE_W     = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = STEP_W;

  // phase may exceed the step width by one bit before the interval wrap
  localparam int PHASE_W = STEP_W + 1;
  localparam int CNT_W   = $clog2(MAX_UPSAMPLE + 1);
  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;
  localparam int ACC_W   = PROD_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_CHOICE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS_RESAMPLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP      = 2'd3;

  // register reset values
  localparam logic [SRC_W-1:0]    RST_SOURCE_CHANNELS = 3'd2;
  localparam logic [CHOICE_W-1:0] RST_CHANNEL_CHOICE  = 3'd0;
  localparam logic                RST_BYPASS_RESAMPLE = 1'b1;
  localparam logic [STEP_W-1:0]   RST_PHASE_STEP      = 20'd65537;

  // channel counts and choices
  localparam logic [SRC_W-1:0]    SRC_TWO    = 3'd2;
  localparam logic [SRC_W-1:0]    SRC_FOUR   = 3'd4;
  localparam logic [CHOICE_W-1:0] CHOICE_CH1 = 3'd1;
  localparam logic [CHOICE_W-1:0] CHOICE_CH2 = 3'd2;
  localparam logic [CHOICE_W-1:0] CHOICE_CH3 = 3'd3;
  localparam logic [CHOICE_W-1:0] CHOICE_CH4 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PASS,
    ST_MUL,
    ST_EMIT,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the mono sample of the accepted word
    logic prime;   // first sample only loads prev
    logic mul;     // register the interpolation product
    logic emit;    // write one interpolated word, advance phase
    logic pass;    // write the mono sample straight through
    logic finish;  // wrap phase into the next interval, shift prev
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bypass;
    logic primed;
    logic in_range;  // phase below one sample
    logic last;      // word being emitted ends the run
    logic out_free;  // output register can take a word
  } dp_status_t;

endpackage

// ===== rtl/core/downmix_linear_resampler.sv =====
// ----------------------------------------------------------------------------
// downmix_linear_resampler
// Mono downmix of a four-channel frame followed by a linear-interpolation
// sample rate converter with a fixed-point phase accumulator.
// ----------------------------------------------------------------------------
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   input    | in_valid / in_ready  | ch0, ch1, ch2, ch3
//   output   | out_valid / out_ready| out_sample, last_of_run
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a frame is captured in ST_IDLE and classified in ST_DECIDE; a priming frame ends there
// bypass adds ST_PASS for the pass-through word
// each interpolated word goes through ST_MUL (product register), then ST_EMIT (the add and shift),
// and ST_FINISH wraps the phase once the run ends
// reset restores the register defaults and clears phase and priming
// a stalled output holds the sequencer; the next frame is taken while the last word waits
// ----------------------------------------------------------------------------
module downmix_linear_resampler
  import dmlr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_W-1:0]   ch0,
  input  logic signed [SAMPLE_W-1:0]   ch1,
  input  logic signed [SAMPLE_W-1:0]   ch2,
  input  logic signed [SAMPLE_W-1:0]   ch3,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_W-1:0]   out_sample,
  output logic                         last_of_run,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  dmlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dmlr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ch0         (ch0),
    .ch1         (ch1),
    .ch2         (ch2),
    .ch3         (ch3),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample),
    .last_of_run (last_of_run)
  );

endmodule

// ===== rtl/core/dmlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmlr_ctrl
// Sequencer for one input frame: prime, bypass, interpolation run or a frame with no word.
// ----------------------------------------------------------------------------
module dmlr_ctrl
  import dmlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (status.bypass) begin
          state_next = ST_PASS;
        end else if (!status.primed) begin
          cmd.prime  = 1'b1;
          state_next = ST_IDLE;
        end else if (status.in_range) begin
          state_next = ST_MUL;
        end else begin
          // downsampling: no word for this frame
          state_next = ST_FINISH;
        end
      end
      ST_PASS: begin
        if (status.out_free) begin
          cmd.pass   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.last ? ST_FINISH : ST_MUL;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/dmlr_datapath.sv =====
// ----------------------------------------------------------------------------
// dmlr_datapath
// Config registers, channel select, phase accumulator, interpolator and
// output register.
// ----------------------------------------------------------------------------
module dmlr_datapath
  import dmlr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [SAMPLE_W-1:0]   ch0,
  input  logic signed [SAMPLE_W-1:0]   ch1,
  input  logic signed [SAMPLE_W-1:0]   ch2,
  input  logic signed [SAMPLE_W-1:0]   ch3,
  input  dp_cmd_t                      cmd,
  output dp_status_t                   status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_W-1:0]   out_sample,
  output logic                         last_of_run
);

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;

  logic [SRC_W-1:0]           source_channels;
  logic [CHOICE_W-1:0]        channel_choice;
  logic                       bypass_resample;
  logic [STEP_W-1:0]          phase_step;

  logic signed [SAMPLE_W-1:0] cur;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic [PHASE_W-1:0]         phase;
  logic                       primed;
  logic [CNT_W-1:0]           cnt;
  logic signed [PROD_W-1:0]   prod;

  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [SAMPLE_W:0]   pair_adj;
  logic signed [SAMPLE_W-1:0] avg;
  logic signed [SAMPLE_W-1:0] mono;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   frac;
  logic signed [ACC_W-1:0]    acc;
  logic                       round_up;
  logic signed [SAMPLE_W-1:0] interp;
  logic [PHASE_W-1:0]         phase_adv;
  logic [CNT_W-1:0]           cnt_inc;
  logic                       out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      source_channels <= RST_SOURCE_CHANNELS;
      channel_choice  <= RST_CHANNEL_CHOICE;
      bypass_resample <= RST_BYPASS_RESAMPLE;
      phase_step      <= RST_PHASE_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_CHANNELS: source_channels <= cfg_data[SRC_W-1:0];
        REG_CHANNEL_CHOICE:  channel_choice  <= cfg_data[CHOICE_W-1:0];
        REG_BYPASS_RESAMPLE: bypass_resample <= cfg_data[0];
        REG_PHASE_STEP:      phase_step      <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // average of the first pair, truncated toward zero
  assign pair_sum = {ch0[SAMPLE_W-1], ch0} + {ch1[SAMPLE_W-1], ch1};
  assign pair_adj = pair_sum + {{SAMPLE_W{1'b0}}, (pair_sum[SAMPLE_W] & pair_sum[0])};
  assign avg      = pair_adj[SAMPLE_W:1];

  always_comb begin
    mono = avg;
    if (source_channels == SRC_TWO) begin
      if (channel_choice == CHOICE_CH1) begin
        mono = ch0;
      end else if (channel_choice == CHOICE_CH2) begin
        mono = ch1;
      end
    end else if (source_channels == SRC_FOUR) begin
      if (channel_choice == CHOICE_CH1) begin
        mono = ch0;
      end else if (channel_choice == CHOICE_CH2) begin
        mono = ch1;
      end else if (channel_choice == CHOICE_CH3) begin
        mono = ch2;
      end else if (channel_choice == CHOICE_CH4) begin
        mono = ch3;
      end
    end else begin
      mono = ch0;
    end
  end

  // interpolation
  assign diff = {prev_sample[SAMPLE_W-1], prev_sample} - {cur[SAMPLE_W-1], cur};
  assign frac = {1'b0, phase[FRAC_BITS-1:0]};
  assign acc  = {prod[PROD_W-1], prod}
              + {{(ACC_W-SAMPLE_W-FRAC_BITS){cur[SAMPLE_W-1]}}, cur, {FRAC_BITS{1'b0}}};
  // arithmetic shift floors, so bump negative values with a fraction
  assign round_up = acc[ACC_W-1] & (|acc[FRAC_BITS-1:0]);
  assign interp   = acc[FRAC_BITS+SAMPLE_W-1:FRAC_BITS]
                  + {{(SAMPLE_W-1){1'b0}}, round_up};

  assign phase_adv = phase + {1'b0, phase_step};
  assign cnt_inc   = cnt + CNT_W'(1);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= mono;
    end
    if (cmd.mul) begin
      prod <= diff * frac;
    end
    if (cmd.prime || cmd.finish) begin
      prev_sample <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      primed <= 1'b0;
      cnt    <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_BYPASS_RESAMPLE || cfg_index == REG_PHASE_STEP)) begin
        phase  <= '0;
        primed <= 1'b0;
      end else begin
        if (cmd.prime) begin
          primed <= 1'b1;
        end
        if (cmd.emit) begin
          phase <= phase_adv;
        end else if (cmd.finish) begin
          // positions dropped at the cap restart the next interval at zero
          phase <= status.in_range ? '0 : phase - PHASE_ONE;
        end
      end
      if (cmd.emit) begin
        cnt <= cnt_inc;
      end else if (cmd.finish) begin
        cnt <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.pass) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample  <= interp;
      last_of_run <= status.last;
    end else if (cmd.pass) begin
      out_sample  <= cur;
      last_of_run <= 1'b1;
    end
  end

  always_comb begin
    status          = '0;
    status.bypass   = bypass_resample;
    status.primed   = primed;
    status.in_range = (phase[PHASE_W-1:FRAC_BITS] == '0);
    status.last     = (cnt_inc == CNT_W'(MAX_UPSAMPLE))
                   || (phase_adv[PHASE_W-1:FRAC_BITS] != '0);
    status.out_free = out_free;
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_UPSAMPLE))
    else $error("run count above cap");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.pass) |-> out_free)
    else $error("word written over a pending output");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.in_range)
    else $error("interpolation with phase beyond the interval");

  a_finish_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !phase[PHASE_W-1])
    else $error("phase not wrapped after run");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last) |=> (out_valid && last_of_run))
    else $error("final word of run not flagged");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mono downmix and linear-interpolation resampler.
// A scoreboard class predicts every output word from each accepted frame
// and compares the words as they leave the block. Directed frames cover the
// sample extremes, every channel selection and the rate cases. Random phases
// that follow change the settings between bursts of random frames, while both
// sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import dmlr_pkg::*;

  localparam int HOLD_CYCLES = 40;    // settle time once the last word is out
  localparam int STUCK_LIMIT = 1000;  // cycles with no handshake at all

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } word_t;

  class mono_resample_scoreboard;
    logic [SRC_W-1:0]           src_channels;
    logic [CHOICE_W-1:0]        choice;
    logic                       bypass;
    logic [STEP_W-1:0]          step;
    logic signed [SAMPLE_W-1:0] prev;
    longint                     phase;
    bit                         primed;
    word_t                      pending[$];
    int                         errors;
    int                         words_checked;
    int                         frames_in;

    function new();
      src_channels  = RST_SOURCE_CHANNELS;
      choice        = RST_CHANNEL_CHOICE;
      bypass        = RST_BYPASS_RESAMPLE;
      step          = RST_PHASE_STEP;
      prev          = '0;
      phase         = 0;
      primed        = 0;
      errors        = 0;
      words_checked = 0;
      frames_in     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SOURCE_CHANNELS: src_channels = data[SRC_W-1:0];
        REG_CHANNEL_CHOICE:  choice = data[CHOICE_W-1:0];
        REG_BYPASS_RESAMPLE: begin
          bypass = data[0];
          phase  = 0;
          primed = 0;
        end
        REG_PHASE_STEP: begin
          step   = data[STEP_W-1:0];
          phase  = 0;
          primed = 0;
        end
        default: ;
      endcase
    endfunction

    function longint mono(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b,
                          logic signed [SAMPLE_W-1:0] c, logic signed [SAMPLE_W-1:0] d);
      longint v[4];
      v[0] = longint'(a);
      v[1] = longint'(b);
      v[2] = longint'(c);
      v[3] = longint'(d);
      if (src_channels == SRC_TWO) begin
        if (choice == CHOICE_CH1) return v[0];
        if (choice == CHOICE_CH2) return v[1];
      end else if (src_channels == SRC_FOUR) begin
        if (choice >= CHOICE_CH1 && choice <= CHOICE_CH4) return v[int'(choice) - 1];
      end else begin
        return v[0];
      end
      // average truncates toward zero
      return (v[0] + v[1]) / 2;
    endfunction

    function void note_frame(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b,
                             logic signed [SAMPLE_W-1:0] c, logic signed [SAMPLE_W-1:0] d);
      longint cur;
      longint one;
      longint acc;
      longint y;
      int     n;
      word_t  w;
      one = longint'(1) << FRAC_BITS;
      cur = mono(a, b, c, d);
      frames_in++;
      if (bypass) begin
        w.sample = cur[SAMPLE_W-1:0];
        w.last   = 1'b1;
        pending.push_back(w);
        return;
      end
      if (!primed) begin
        prev   = cur[SAMPLE_W-1:0];
        primed = 1;
        return;
      end
      n = 0;
      while (phase < one && n < MAX_UPSAMPLE) begin
        acc      = (longint'(prev) - cur) * phase + cur * one;
        y        = acc / one;
        w.sample = y[SAMPLE_W-1:0];
        // run ends when the next position leaves the interval or the cap is hit
        w.last   = (phase + longint'(step) >= one) || (n + 1 >= MAX_UPSAMPLE);
        pending.push_back(w);
        n++;
        phase += longint'(step);
      end
      if (phase < one) phase = 0;
      else phase -= one;
      prev = cur[SAMPLE_W-1:0];
    endfunction

    function void check_word(logic signed [SAMPLE_W-1:0] s, logic l);
      word_t w;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected word: out_sample %0d last_of_run %0b", $time, s, l);
        return;
      end
      w = pending.pop_front();
      words_checked++;
      if (s !== w.sample) begin
        errors++;
        $display("%0t out_sample mismatch: expected %0d, got %0d", $time, w.sample, s);
      end
      if (l !== w.last) begin
        errors++;
        $display("%0t last_of_run mismatch: expected %0b, got %0b", $time, w.last, l);
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  ch0;
  logic signed [SAMPLE_W-1:0]  ch1;
  logic signed [SAMPLE_W-1:0]  ch2;
  logic signed [SAMPLE_W-1:0]  ch3;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [SAMPLE_W-1:0]  out_sample;
  logic                        last_of_run;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;

  mono_resample_scoreboard sb;
  bit steady;
  int reg_writes;
  int settings;
  int stuck;

  downmix_linear_resampler u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch0         (ch0),
    .ch1         (ch1),
    .ch2         (ch2),
    .ch3         (ch3),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // output side: random stall before each word
  initial begin : out_side
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) sb.check_word(out_sample, last_of_run);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("%0t no handshake for %0d cycles", $time, STUCK_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return -16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] a,
                            input logic signed [SAMPLE_W-1:0] b,
                            input logic signed [SAMPLE_W-1:0] c,
                            input logic signed [SAMPLE_W-1:0] d);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch0      <= a;
    ch1      <= b;
    ch2      <= c;
    ch3      <= d;
    do @(posedge clk); while (!(in_valid && in_ready === 1'b1));
    sb.note_frame(a, b, c, d);
  endtask

  // stop sending and wait for every predicted word
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // frames with no output may still be in flight after the last word
  task automatic quiesce();
    drain();
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready === 1'b1));
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] src,
                               input logic [CFG_DATA_W-1:0] choice,
                               input bit rate, input logic [CFG_DATA_W-1:0] bypass,
                               input logic [CFG_DATA_W-1:0] step);
    quiesce();
    put_reg(REG_SOURCE_CHANNELS, src);
    put_reg(REG_CHANNEL_CHOICE, choice);
    if (rate) begin
      put_reg(REG_BYPASS_RESAMPLE, bypass);
      put_reg(REG_PHASE_STEP, step);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    int                    ph;
    int                    k;
    logic [CFG_DATA_W-1:0] src_d;
    logic [CFG_DATA_W-1:0] choice_d;
    logic [CFG_DATA_W-1:0] bypass_d;
    logic [CFG_DATA_W-1:0] step_d;
    bit                    rate;
    sb         = new();
    steady     = 0;
    reg_writes = 0;
    settings   = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    ch0       <= '0;
    ch1       <= '0;
    ch2       <= '0;
    ch3       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SOURCE_CHANNELS;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: two channels averaged, pass-through
    send_frame(S_MAX, S_MAX, 16'sd0, 16'sd0);
    send_frame(S_MIN, S_MIN, S_MAX, S_MAX);
    send_frame(-16'sd3, 16'sd0, 16'sd0, 16'sd0);   // average rounds toward zero
    send_frame(S_MAX, S_MIN, 16'sd0, 16'sd0);
    // upper data bits of the channel count are dropped
    apply_setting(20'hFFFF4, CFG_DATA_W'(CHOICE_CH3), 0, 0, 0);
    send_frame(16'sd1, 16'sd2, S_MIN, 16'sd4);
    apply_setting(CFG_DATA_W'(SRC_FOUR), CFG_DATA_W'(CHOICE_CH4), 0, 0, 0);
    send_frame(16'sd1, 16'sd2, 16'sd3, S_MAX);
    apply_setting(CFG_DATA_W'(SRC_FOUR), 7, 0, 0, 0);   // choice out of range averages
    send_frame(16'sd5, -16'sd8, 16'sd9, 16'sd10);
    apply_setting(3, CFG_DATA_W'(CHOICE_CH2), 0, 0, 0); // odd count takes the first channel
    send_frame(S_MIN, 16'sd7, 16'sd8, 16'sd9);
    apply_setting(CFG_DATA_W'(SRC_TWO), CFG_DATA_W'(CHOICE_CH2), 0, 0, 0);
    send_frame(16'sd0, -16'sd1, 16'sd0, 16'sd0);

    // resampling, twice the input rate; first frame only primes
    apply_setting(CFG_DATA_W'(SRC_TWO), CFG_DATA_W'(CHOICE_CH1), 1, 0, 32768);
    send_frame(S_MAX, 16'sd0, 16'sd0, 16'sd0);
    send_frame(S_MIN, 16'sd0, 16'sd0, 16'sd0);
    send_frame(S_MAX, 16'sd0, 16'sd0, 16'sd0);
    send_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // small step: the output cap cuts the run short
    apply_setting(CFG_DATA_W'(SRC_TWO), CFG_DATA_W'(CHOICE_CH1), 1, 0, 5000);
    send_frame(S_MIN, 16'sd0, 16'sd0, 16'sd0);
    send_frame(S_MAX, 16'sd0, 16'sd0, 16'sd0);
    send_frame(-16'sd1234, 16'sd0, 16'sd0, 16'sd0);
    apply_setting(CFG_DATA_W'(SRC_TWO), CFG_DATA_W'(CHOICE_CH1), 1, 0, 0);
    send_frame(16'sd100, 16'sd0, 16'sd0, 16'sd0);
    send_frame(-16'sd100, 16'sd0, 16'sd0, 16'sd0);
    // half rate: every other frame gives no word
    apply_setting(CFG_DATA_W'(SRC_TWO), CFG_DATA_W'(CHOICE_CH1), 1, 0, 131072);
    send_frame(16'sd300, 16'sd0, 16'sd0, 16'sd0);
    send_frame(S_MAX, 16'sd0, 16'sd0, 16'sd0);
    send_frame(S_MIN, 16'sd0, 16'sd0, 16'sd0);
    send_frame(16'sd5, 16'sd0, 16'sd0, 16'sd0);
    // changing the selection keeps the phase running
    apply_setting(CFG_DATA_W'(SRC_TWO), CFG_DATA_W'(CHOICE_CH2), 0, 0, 0);
    send_frame(16'sd0, S_MIN, 16'sd0, 16'sd0);

    for (ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 5))
        0:       src_d = 1;
        1, 2:    src_d = CFG_DATA_W'(SRC_TWO);
        3, 4:    src_d = CFG_DATA_W'(SRC_FOUR);
        default: src_d = CFG_DATA_W'($urandom_range(0, 7));
      endcase
      src_d    = CFG_DATA_W'($urandom & 20'hFFFF8) | src_d;
      choice_d = CFG_DATA_W'($urandom_range(0, 7));
      bypass_d = CFG_DATA_W'($urandom & 20'hFFFFE) | CFG_DATA_W'($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0:       step_d = 8192;
        1:       step_d = 524288;
        2:       step_d = 65536;
        3:       step_d = RST_PHASE_STEP;
        4:       step_d = CFG_DATA_W'($urandom_range(0, 8191));
        default: step_d = CFG_DATA_W'($urandom_range(8192, 524288));
      endcase
      rate = (ph < 2) || ($urandom_range(0, 2) != 0);
      apply_setting(src_d, choice_d, rate, bypass_d, step_d);
      steady = (ph % 4 == 3);
      for (k = 0; k < 28; k++) begin
        if (k == 15 && ph % 2 == 1) drain();
        send_frame(pick_value(), pick_value(), pick_value(), pick_value());
      end
    end

    quiesce();
    $display("summary: %0d frames in, %0d words checked, %0d register writes, %0d settings",
             sb.frames_in, sb.words_checked, reg_writes, settings);
    $display("summary: pass-through, up, down and capped rates with all channel selections");
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== downmix_linear_resampler.f =====
rtl/core/dmlr_pkg.sv
rtl/core/dmlr_ctrl.sv
rtl/core/dmlr_datapath.sv
rtl/core/downmix_linear_resampler.sv
bench/tb_top.sv
